### hdl/assert_macros.svh
// assertion macros shared by the rtl files of the segment structure check
// depends on nothing; included by the files that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent holds at an edge -> consequent holds at the same edge
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// antecedent holds at an edge -> consequent holds at the next edge
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

// property holds at every edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

`endif

### hdl/jssc_pkg.sv
// types and constants of the jpeg segment structure check
// no dependencies; used by all modules
`default_nettype none

package jssc_pkg;

    // byte codes of the jpeg marker syntax
    localparam logic [7:0] BYTE_FILL  = 8'hFF;
    localparam logic [7:0] CODE_SOI   = 8'hD8;
    localparam logic [7:0] CODE_EOI   = 8'hD9;
    localparam logic [7:0] CODE_SOS   = 8'hDA;
    localparam logic [7:0] CODE_SOF0  = 8'hC0;
    localparam logic [7:0] CODE_SOF1  = 8'hC1;
    localparam logic [7:0] CODE_DQT   = 8'hDB;
    localparam logic [7:0] CODE_DHT   = 8'hC4;

    // segment header length field counts itself
    localparam logic [15:0] LEN_MIN   = 16'd2;

    // byte counter saturates once the frame is long enough
    localparam int          COUNT_W   = 3;
    localparam logic [COUNT_W-1:0] COUNT_SAT   = 3'd4;
    localparam logic [COUNT_W-1:0] COUNT_SHORT = 3'd3;

    // seen flag bit positions
    localparam int FLAG_SOF = 0;
    localparam int FLAG_DQT = 1;
    localparam int FLAG_DHT = 2;
    localparam int FLAG_SOS = 3;
    localparam int FLAG_W   = 4;

    typedef enum logic [3:0] {
        PH_FIRST  = 4'd0,
        PH_SECOND = 4'd1,
        PH_EXPFF  = 4'd2,
        PH_MARKER = 4'd3,
        PH_LENHI  = 4'd4,
        PH_LENLO  = 4'd5,
        PH_SKIP   = 4'd6,
        PH_STOP   = 4'd7,
        PH_NOSOI  = 4'd8
    } t_phase;

    typedef enum logic [1:0] {
        STAT_INSPECTED = 2'd0,
        STAT_SHORT     = 2'd1,
        STAT_NO_SOI    = 2'd2
    } t_status;

    // walk state carried between the top level and the walk logic
    typedef struct packed {
        t_phase              phase;
        logic [15:0]         skip;
        logic [7:0]          len_hi;
        logic [7:0]          marker;
        logic [FLAG_W-1:0]   seen;
    } t_walk_state;

    localparam t_walk_state WALK_RESET = '{
        phase:  PH_FIRST,
        skip:   16'd0,
        len_hi: 8'd0,
        marker: 8'd0,
        seen:   '0
    };

endpackage

`default_nettype wire

### hdl/jssc_in_if.sv
// byte input channel of the segment structure check
// depends on nothing but the handshake convention valid/ready
`default_nettype none

interface jssc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

### hdl/jssc_out_if.sv
// result channel of the segment structure check
// depends on nothing but the handshake convention valid/ready
`default_nettype none

interface jssc_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic       sof_seen;
    logic       dqt_seen;
    logic       dht_seen;
    logic       sos_seen;
    logic       eoi_at_end;

    modport source (output valid, output status, output sof_seen, output dqt_seen,
                    output dht_seen, output sos_seen, output eoi_at_end, input ready);
    modport sink   (input valid, input status, input sof_seen, input dqt_seen,
                    input dht_seen, input sos_seen, input eoi_at_end, output ready);
endinterface

`default_nettype wire

### hdl/jssc_walk.sv
// next-state logic of the marker segment walk, one byte per evaluation
// depends on jssc_pkg
`default_nettype none

module jssc_walk (
    input  jssc_pkg::t_walk_state i_state,
    input  logic [7:0]            i_byte,
    output jssc_pkg::t_walk_state o_state
);

    logic [15:0] w_seglen;
    logic [15:0] w_skip_dec;

    assign w_seglen   = {i_state.len_hi, i_byte};
    assign w_skip_dec = (i_state.skip != 16'd0) ? (i_state.skip - 16'd1) : i_state.skip;

    // one step of the walk
    always_comb begin
        o_state = i_state;
        unique case (i_state.phase)
            jssc_pkg::PH_FIRST: begin
                o_state.phase = (i_byte == jssc_pkg::BYTE_FILL) ?
                                jssc_pkg::PH_SECOND : jssc_pkg::PH_NOSOI;
            end
            jssc_pkg::PH_SECOND: begin
                o_state.phase = (i_byte == jssc_pkg::CODE_SOI) ?
                                jssc_pkg::PH_EXPFF : jssc_pkg::PH_NOSOI;
            end
            jssc_pkg::PH_EXPFF: begin
                o_state.phase = (i_byte == jssc_pkg::BYTE_FILL) ?
                                jssc_pkg::PH_MARKER : jssc_pkg::PH_STOP;
            end
            jssc_pkg::PH_MARKER: begin
                // fill bytes keep the phase
                priority if (i_byte == jssc_pkg::BYTE_FILL) begin
                    o_state.phase = jssc_pkg::PH_MARKER;
                end else if (i_byte == jssc_pkg::CODE_EOI) begin
                    o_state.phase = jssc_pkg::PH_STOP;
                end else if (i_byte == jssc_pkg::CODE_SOS) begin
                    o_state.seen[jssc_pkg::FLAG_SOS] = 1'b1;
                    o_state.phase = jssc_pkg::PH_STOP;
                end else begin
                    o_state.marker = i_byte;
                    o_state.phase  = jssc_pkg::PH_LENHI;
                end
            end
            jssc_pkg::PH_LENHI: begin
                o_state.len_hi = i_byte;
                o_state.phase  = jssc_pkg::PH_LENLO;
            end
            jssc_pkg::PH_LENLO: begin
                if (w_seglen < jssc_pkg::LEN_MIN) begin
                    o_state.phase = jssc_pkg::PH_STOP;
                end else begin
                    // flag goes up as soon as the length is known
                    priority if (i_state.marker == jssc_pkg::CODE_SOF0 ||
                                 i_state.marker == jssc_pkg::CODE_SOF1) begin
                        o_state.seen[jssc_pkg::FLAG_SOF] = 1'b1;
                    end else if (i_state.marker == jssc_pkg::CODE_DQT) begin
                        o_state.seen[jssc_pkg::FLAG_DQT] = 1'b1;
                    end else if (i_state.marker == jssc_pkg::CODE_DHT) begin
                        o_state.seen[jssc_pkg::FLAG_DHT] = 1'b1;
                    end else begin
                        o_state.seen = i_state.seen;
                    end
                    o_state.skip  = w_seglen - jssc_pkg::LEN_MIN;
                    o_state.phase = (w_seglen == jssc_pkg::LEN_MIN) ?
                                    jssc_pkg::PH_EXPFF : jssc_pkg::PH_SKIP;
                end
            end
            jssc_pkg::PH_SKIP: begin
                o_state.skip = w_skip_dec;
                if (w_skip_dec == 16'd0) begin
                    o_state.phase = jssc_pkg::PH_EXPFF;
                end
            end
            jssc_pkg::PH_STOP: begin
                o_state.phase = jssc_pkg::PH_STOP;
            end
            jssc_pkg::PH_NOSOI: begin
                o_state.phase = jssc_pkg::PH_NOSOI;
            end
            default: begin
                o_state.phase = jssc_pkg::PH_STOP;
            end
        endcase
    end

endmodule

`default_nettype wire

### hdl/jssc_result.sv
// result register of the segment structure check: forms and holds one result
// depends on jssc_pkg, jssc_out_if and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module jssc_result (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_load,
    input  logic [jssc_pkg::COUNT_W-1:0] i_count,
    input  jssc_pkg::t_phase       i_phase,
    input  logic [jssc_pkg::FLAG_W-1:0]  i_seen,
    input  logic [7:0]             i_prev,
    input  logic [7:0]             i_byte,
    output logic                   o_free,
    jssc_out_if.source             o_out
);

    logic                         r_valid;
    jssc_pkg::t_status            r_status;
    logic [jssc_pkg::FLAG_W-1:0]  r_flags;
    logic                         r_eoi;
    jssc_pkg::t_status            n_status;
    logic [jssc_pkg::FLAG_W-1:0]  n_flags;
    logic                         n_eoi;

    // slot is free when empty or drained in this cycle
    assign o_free = !r_valid || o_out.ready;

    // result of the frame's last byte; count is the value before this byte
    always_comb begin
        n_flags = '0;
        n_eoi   = 1'b0;
        priority if (i_count < jssc_pkg::COUNT_SHORT) begin
            n_status = jssc_pkg::STAT_SHORT;
        end else if (i_phase == jssc_pkg::PH_NOSOI) begin
            n_status = jssc_pkg::STAT_NO_SOI;
        end else begin
            n_status = jssc_pkg::STAT_INSPECTED;
            n_flags  = i_seen;
            n_eoi    = (i_count != '0) && (i_prev == jssc_pkg::BYTE_FILL) &&
                       (i_byte == jssc_pkg::CODE_EOI);
        end
    end

    // valid bit of the result slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    // payload of the result slot
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_status <= n_status;
            r_flags  <= n_flags;
            r_eoi    <= n_eoi;
        end
    end

    assign o_out.valid      = r_valid;
    assign o_out.status     = r_status;
    assign o_out.sof_seen   = r_flags[jssc_pkg::FLAG_SOF];
    assign o_out.dqt_seen   = r_flags[jssc_pkg::FLAG_DQT];
    assign o_out.dht_seen   = r_flags[jssc_pkg::FLAG_DHT];
    assign o_out.sos_seen   = r_flags[jssc_pkg::FLAG_SOS];
    assign o_out.eoi_at_end = r_eoi;

    // a load never lands on a result that is still waiting
    `ASSERT_IMPLY(a_no_overwrite, i_clk, i_rst_n, i_load, o_free)
    // a failed frame reports no segment flags
    `ASSERT_IMPLY(a_fail_no_flags, i_clk, i_rst_n,
        r_valid && (r_status != jssc_pkg::STAT_INSPECTED), (r_flags == '0) && !r_eoi)

endmodule

`default_nettype wire

### hdl/jssc_top_unused_guard.sv
// holds no logic of its own; the walk state register is module jssc_state_reg
// in jssc_state.sv, which the top level instantiates
`default_nettype none

`default_nettype wire

### hdl/jssc_state.sv
// walk state register of the segment structure check
// depends on jssc_pkg, jssc_walk and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module jssc_state_reg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_accept,
    input  logic                         i_last,
    input  logic [7:0]                   i_byte,
    output jssc_pkg::t_walk_state        o_state,
    output logic [jssc_pkg::COUNT_W-1:0] o_count,
    output logic [7:0]                   o_prev
);

    jssc_pkg::t_walk_state        r_walk;
    jssc_pkg::t_walk_state        n_walk;
    logic [jssc_pkg::COUNT_W-1:0] r_count;
    logic [7:0]                   r_prev;

    jssc_walk u_walk (
        .i_state (r_walk),
        .i_byte  (i_byte),
        .o_state (n_walk)
    );

    // state advances per accepted byte and clears after the last one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_walk  <= jssc_pkg::WALK_RESET;
            r_count <= '0;
            r_prev  <= 8'd0;
        end else if (i_accept) begin
            if (i_last) begin
                r_walk  <= jssc_pkg::WALK_RESET;
                r_count <= '0;
                r_prev  <= 8'd0;
            end else begin
                r_walk  <= n_walk;
                r_prev  <= i_byte;
                if (r_count < jssc_pkg::COUNT_SAT) begin
                    r_count <= r_count + {{(jssc_pkg::COUNT_W-1){1'b0}}, 1'b1};
                end
            end
        end
    end

    assign o_state = n_walk;
    assign o_count = r_count;
    assign o_prev  = r_prev;

    `ASSERT_ALWAYS(a_count_sat, i_clk, i_rst_n, r_count <= jssc_pkg::COUNT_SAT)
    `ASSERT_NEXT(a_frame_restart, i_clk, i_rst_n, i_accept && i_last,
        (r_walk.phase == jssc_pkg::PH_FIRST) && (r_count == '0) && (r_walk.seen == '0))

endmodule

`default_nettype wire

### hdl/jpeg_segment_structure_check.sv
// Takes a JPEG frame one byte per transfer and walks its marker segments
// (start-of-image, fill bytes, length-skipped payloads, SOF/DQT/DHT/SOS); on
// the byte flagged last it delivers one result: status, segment flags and
// whether the frame ends in FF D9. A byte is taken every cycle: the walk state
// updates through a single register, and the result sits in an output
// register, so bytes keep flowing as long as each result is taken.
// The result is valid the cycle after its last byte; input stalls, for any
// byte, in every cycle where a result is still waiting and the output is not
// ready.
// Depends on jssc_pkg, jssc_in_if, jssc_out_if, jssc_state_reg, jssc_result.
`default_nettype none
`include "assert_macros.svh"

module jpeg_segment_structure_check (
    input  logic      i_clk,
    input  logic      i_rst_n,
    jssc_in_if.sink   i_in,
    jssc_out_if.source o_out
);

    logic                         w_accept;
    logic                         w_free;
    logic                         w_load;
    jssc_pkg::t_walk_state        w_next;
    logic [jssc_pkg::COUNT_W-1:0] w_count;
    logic [7:0]                   w_prev;

    // input transfer is taken whenever the result slot can absorb a result
    assign i_in.ready = w_free;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_load     = w_accept && i_in.last_byte;

    jssc_state_reg u_state (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_last   (i_in.last_byte),
        .i_byte   (i_in.data_byte),
        .o_state  (w_next),
        .o_count  (w_count),
        .o_prev   (w_prev)
    );

    jssc_result u_result (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_load),
        .i_count (w_count),
        .i_phase (w_next.phase),
        .i_seen  (w_next.seen),
        .i_prev  (w_prev),
        .i_byte  (i_in.data_byte),
        .o_free  (w_free),
        .o_out   (o_out)
    );

    // a result only appears after a last-byte transfer
    `ASSERT_IMPLY(a_result_cause, i_clk, i_rst_n, $rose(o_out.valid),
        $past(i_in.valid && i_in.ready && i_in.last_byte))

endmodule

`default_nettype wire

### tb/sv/jpeg_segment_structure_check_tb.sv
// self-checking testbench for the jpeg segment structure check: random and directed frames
// depends on jssc_pkg, jssc_in_if, jssc_out_if and jpeg_segment_structure_check from hdl

module jpeg_segment_structure_check_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_BYTES   = 1500;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 12;
    localparam int REPORT_LIMIT   = 10;
    // a segment code with no flag of its own
    localparam logic [7:0] CODE_APP1 = 8'hE1;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_frame_byte;

    typedef struct packed {
        jssc_pkg::t_status status;
        logic    sof;
        logic    dqt;
        logic    dht;
        logic    sos;
        logic    eoi;
    } t_frame_verdict;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    // stimulus drive registers, known from time zero
    logic       drv_valid = 1'b0;
    logic [7:0] drv_data = 8'h00;
    logic       drv_last = 1'b0;
    logic       rcv_ready = 1'b0;
    logic       in_took = 1'b0;

    jssc_in_if  in_if ();
    jssc_out_if out_if ();

    assign in_if.valid     = drv_valid;
    assign in_if.data_byte = drv_data;
    assign in_if.last_byte = drv_last;
    assign out_if.ready    = rcv_ready;

    jpeg_segment_structure_check dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always #4 i_clk = ~i_clk;

    t_frame_byte    byte_queue[$];
    logic [7:0]     frame_buf[$];
    t_frame_verdict verdicts_due[$];

    int bytes_total = 0;
    int bytes_accepted = 0;
    int fail_count = 0;
    int idle_cycles = 0;
    int gap_left = 0;
    int burst_left = 1;

    // walk state of the frame being tracked
    jssc_pkg::t_phase                walk_phase = jssc_pkg::PH_FIRST;
    logic [15:0]                     skip_left = '0;
    logic [7:0]                      len_hi_q = '0;
    logic [7:0]                      marker_q = '0;
    logic [7:0]                      prev_q = '0;
    logic [jssc_pkg::COUNT_W-1:0]    count_q = '0;
    logic [jssc_pkg::FLAG_W-1:0]     seen_q = '0;

    // advance the segment walk by one byte
    function automatic void walk_segments(input logic [7:0] b);
        logic [15:0] seg_len;
        case (walk_phase)
            jssc_pkg::PH_FIRST:
                walk_phase = (b == jssc_pkg::BYTE_FILL) ? jssc_pkg::PH_SECOND
                                                        : jssc_pkg::PH_NOSOI;
            jssc_pkg::PH_SECOND:
                walk_phase = (b == jssc_pkg::CODE_SOI) ? jssc_pkg::PH_EXPFF
                                                       : jssc_pkg::PH_NOSOI;
            jssc_pkg::PH_EXPFF:
                walk_phase = (b == jssc_pkg::BYTE_FILL) ? jssc_pkg::PH_MARKER
                                                        : jssc_pkg::PH_STOP;
            jssc_pkg::PH_MARKER: begin
                if (b == jssc_pkg::BYTE_FILL) begin
                    walk_phase = jssc_pkg::PH_MARKER;
                end else if (b == jssc_pkg::CODE_EOI) begin
                    walk_phase = jssc_pkg::PH_STOP;
                end else if (b == jssc_pkg::CODE_SOS) begin
                    seen_q[jssc_pkg::FLAG_SOS] = 1'b1;
                    walk_phase = jssc_pkg::PH_STOP;
                end else begin
                    marker_q = b;
                    walk_phase = jssc_pkg::PH_LENHI;
                end
            end
            jssc_pkg::PH_LENHI: begin
                len_hi_q = b;
                walk_phase = jssc_pkg::PH_LENLO;
            end
            jssc_pkg::PH_LENLO: begin
                seg_len = {len_hi_q, b};
                if (seg_len < jssc_pkg::LEN_MIN) begin
                    walk_phase = jssc_pkg::PH_STOP;
                end else begin
                    if (marker_q == jssc_pkg::CODE_SOF0 || marker_q == jssc_pkg::CODE_SOF1)
                        seen_q[jssc_pkg::FLAG_SOF] = 1'b1;
                    else if (marker_q == jssc_pkg::CODE_DQT)
                        seen_q[jssc_pkg::FLAG_DQT] = 1'b1;
                    else if (marker_q == jssc_pkg::CODE_DHT)
                        seen_q[jssc_pkg::FLAG_DHT] = 1'b1;
                    skip_left = seg_len - jssc_pkg::LEN_MIN;
                    walk_phase = (skip_left == 0) ? jssc_pkg::PH_EXPFF : jssc_pkg::PH_SKIP;
                end
            end
            jssc_pkg::PH_SKIP: begin
                if (skip_left != 0)
                    skip_left = skip_left - 16'd1;
                if (skip_left == 0)
                    walk_phase = jssc_pkg::PH_EXPFF;
            end
            jssc_pkg::PH_STOP, jssc_pkg::PH_NOSOI: ;
            default: walk_phase = jssc_pkg::PH_STOP;
        endcase
    endfunction

    // track one accepted byte; on the last byte queue the frame verdict
    function automatic void track_byte(input logic [7:0] b, input logic last);
        logic           had_prev;
        logic [7:0]     prev;
        t_frame_verdict v;
        had_prev = (count_q != 0);
        prev = prev_q;
        walk_segments(b);
        if (count_q < jssc_pkg::COUNT_SAT)
            count_q = count_q + 1'b1;
        prev_q = b;
        if (last) begin
            v = '0;
            if (count_q < jssc_pkg::COUNT_SAT) begin
                v.status = jssc_pkg::STAT_SHORT;
            end else if (walk_phase == jssc_pkg::PH_NOSOI) begin
                v.status = jssc_pkg::STAT_NO_SOI;
            end else begin
                v.status = jssc_pkg::STAT_INSPECTED;
                v.sof = seen_q[jssc_pkg::FLAG_SOF];
                v.dqt = seen_q[jssc_pkg::FLAG_DQT];
                v.dht = seen_q[jssc_pkg::FLAG_DHT];
                v.sos = seen_q[jssc_pkg::FLAG_SOS];
                v.eoi = had_prev && prev == jssc_pkg::BYTE_FILL && b == jssc_pkg::CODE_EOI;
            end
            verdicts_due.push_back(v);
            walk_phase = jssc_pkg::PH_FIRST;
            skip_left = '0;
            len_hi_q = '0;
            marker_q = '0;
            prev_q = '0;
            count_q = '0;
            seen_q = '0;
        end
    endfunction

    task automatic note_failure(input string what, input t_frame_verdict want,
                                input t_frame_verdict got);
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
            $display("%0t %s: expected status=%0d sof=%0b dqt=%0b dht=%0b sos=%0b eoi=%0b,",
                     $time, what, want.status, want.sof, want.dqt, want.dht, want.sos,
                     want.eoi,
                     " got status=%0d sof=%0b dqt=%0b dht=%0b sos=%0b eoi=%0b",
                     got.status, got.sof, got.dqt, got.dht, got.sos, got.eoi);
    endtask

    // move the frame buffer into the byte queue, last flag on its final byte
    task automatic queue_frame();
        t_frame_byte fb;
        foreach (frame_buf[i]) begin
            fb.data = frame_buf[i];
            fb.last = (i == frame_buf.size() - 1);
            byte_queue.push_back(fb);
        end
        bytes_total += frame_buf.size();
        frame_buf.delete();
    endtask

    task automatic push_random(input int n);
        repeat (n) frame_buf.push_back(8'($urandom));
    endtask

    // frame with start-of-image and random segments, ending in one of several ways
    task automatic build_walkable_frame();
        int          nseg;
        int          pick;
        logic [7:0]  code;
        logic [15:0] seg_len;
        logic        cut;
        cut = 1'b0;
        frame_buf.push_back(jssc_pkg::BYTE_FILL);
        frame_buf.push_back(jssc_pkg::CODE_SOI);
        nseg = $urandom_range(0, 4);
        for (int s = 0; s < nseg && !cut; s++) begin
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 3)) frame_buf.push_back(jssc_pkg::BYTE_FILL);
            frame_buf.push_back(jssc_pkg::BYTE_FILL);
            pick = $urandom_range(0, 5);
            case (pick)
                0: code = jssc_pkg::CODE_SOF0;
                1: code = jssc_pkg::CODE_SOF1;
                2: code = jssc_pkg::CODE_DQT;
                3: code = jssc_pkg::CODE_DHT;
                4: code = CODE_APP1;
                default: begin
                    code = 8'($urandom);
                    if (code == jssc_pkg::BYTE_FILL || code == jssc_pkg::CODE_EOI ||
                        code == jssc_pkg::CODE_SOS)
                        code = CODE_APP1;
                end
            endcase
            frame_buf.push_back(code);
            pick = $urandom_range(0, 15);
            if (pick == 0) begin
                // length below the minimum stops the walk
                seg_len = 16'($urandom_range(0, 1));
            end else if (pick == 1) begin
                // huge length, frame ends inside the payload
                seg_len = 16'($urandom);
                cut = 1'b1;
            end else begin
                seg_len = 16'($urandom_range(2, 8));
            end
            frame_buf.push_back(seg_len[15:8]);
            frame_buf.push_back(seg_len[7:0]);
            if (cut)
                push_random($urandom_range(0, 6));
            else if (seg_len >= jssc_pkg::LEN_MIN)
                push_random(seg_len - jssc_pkg::LEN_MIN);
        end
        if (!cut) begin
            case ($urandom_range(0, 4))
                0, 1: begin
                    frame_buf.push_back(jssc_pkg::BYTE_FILL);
                    frame_buf.push_back(jssc_pkg::CODE_SOS);
                    push_random($urandom_range(0, 6));
                    frame_buf.push_back(jssc_pkg::BYTE_FILL);
                    frame_buf.push_back(jssc_pkg::CODE_EOI);
                end
                2: begin
                    frame_buf.push_back(jssc_pkg::BYTE_FILL);
                    frame_buf.push_back(jssc_pkg::CODE_EOI);
                end
                3: ;
                default: begin
                    frame_buf.push_back(8'($urandom_range(0, 254)));
                    push_random($urandom_range(0, 4));
                end
            endcase
        end
        // occasionally chop the frame at a random point
        if ($urandom_range(0, 9) == 0)
            frame_buf = frame_buf[0:$urandom_range(0, frame_buf.size() - 1)];
    endtask

    // stimulus: directed frames, then random frames
    initial begin
        // single byte, then three bytes: both short
        frame_buf = '{jssc_pkg::BYTE_FILL};
        queue_frame();
        frame_buf = '{jssc_pkg::BYTE_FILL, jssc_pkg::CODE_SOI, jssc_pkg::BYTE_FILL};
        queue_frame();
        // no start-of-image, ends in eoi
        frame_buf = '{8'h00, jssc_pkg::CODE_SOI, jssc_pkg::BYTE_FILL, jssc_pkg::CODE_EOI};
        queue_frame();
        // fill, empty dqt, dht cut off inside its payload
        frame_buf = '{jssc_pkg::BYTE_FILL, jssc_pkg::CODE_SOI, jssc_pkg::BYTE_FILL,
                      jssc_pkg::BYTE_FILL, jssc_pkg::CODE_DQT, 8'h00, 8'h02,
                      jssc_pkg::BYTE_FILL, jssc_pkg::CODE_DHT, 8'h00, 8'h05, 8'h00,
                      jssc_pkg::BYTE_FILL};
        queue_frame();
        // length below two
        frame_buf = '{jssc_pkg::BYTE_FILL, jssc_pkg::CODE_SOI, jssc_pkg::BYTE_FILL,
                      jssc_pkg::CODE_SOF1, 8'h00, 8'h01};
        queue_frame();
        while (bytes_total < RANDOM_BYTES) begin
            if ($urandom_range(0, 3) != 0) begin
                build_walkable_frame();
            end else begin
                // noise, sometimes behind a valid start-of-image
                if ($urandom_range(0, 1) == 0) begin
                    frame_buf.push_back(jssc_pkg::BYTE_FILL);
                    frame_buf.push_back(jssc_pkg::CODE_SOI);
                end
                push_random($urandom_range(1, 10));
            end
            queue_frame();
        end

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (bytes_accepted < bytes_total) @(posedge i_clk);
        while (verdicts_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && verdicts_due.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // sender: bursts of transfers with random gaps in between
    always @(negedge i_clk) begin
        t_frame_byte nxt;
        if (!i_rst_n) begin
            drv_valid <= 1'b0;
        end else if (!drv_valid || in_took) begin
            if (gap_left != 0) begin
                drv_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (byte_queue.size() != 0) begin
                nxt = byte_queue.pop_front();
                drv_valid <= 1'b1;
                drv_data <= nxt.data;
                drv_last <= nxt.last;
                if (burst_left > 1) begin
                    burst_left <= burst_left - 1;
                end else begin
                    burst_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                              : $urandom_range(1, 24);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end else begin
                drv_valid <= 1'b0;
            end
        end
    end

    // receiver: rotating stall pattern, re-rolled every so often
    logic [15:0] stall_pat = 16'hFFFF;
    int          pat_age = 0;

    always @(negedge i_clk) begin
        if (pat_age == 0) begin
            case ($urandom_range(0, 3))
                0: stall_pat = 16'hFFFF;
                1: stall_pat = 16'($urandom) | 16'h0001;
                2: stall_pat = 16'h0101;
                default: stall_pat = 16'h8000 | 16'($urandom_range(0, 3));
            endcase
            pat_age = $urandom_range(16, 128);
        end else begin
            pat_age--;
        end
        rcv_ready <= stall_pat[0];
        stall_pat = {stall_pat[0], stall_pat[15:1]};
    end

    // monitor: track accepted bytes, check delivered verdicts, watchdog
    always @(posedge i_clk) begin
        t_frame_verdict want;
        t_frame_verdict got;
        logic in_fire;
        logic out_fire;
        in_fire = i_rst_n && in_if.valid && in_if.ready;
        out_fire = i_rst_n && out_if.valid && out_if.ready;
        in_took <= in_fire;
        if (in_fire) begin
            track_byte(in_if.data_byte, in_if.last_byte);
            bytes_accepted++;
        end
        if (out_fire) begin
            got.status = jssc_pkg::t_status'(out_if.status);
            got.sof = out_if.sof_seen;
            got.dqt = out_if.dqt_seen;
            got.dht = out_if.dht_seen;
            got.sos = out_if.sos_seen;
            got.eoi = out_if.eoi_at_end;
            if (verdicts_due.size() == 0) begin
                note_failure("unexpected result", '0, got);
            end else begin
                want = verdicts_due.pop_front();
                if (got.status !== want.status || got.sof !== want.sof ||
                    got.dqt !== want.dqt || got.dht !== want.dht ||
                    got.sos !== want.sos || got.eoi !== want.eoi)
                    note_failure("result mismatch", want, got);
            end
        end
        if (i_rst_n) begin
            if (in_fire || out_fire)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

endmodule
